>>> hdl/quoted_word_splitter_assert.svh
// Assertion macros shared by the word splitter RTL.
`ifndef QUOTED_WORD_SPLITTER_ASSERT_SVH
`define QUOTED_WORD_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define QWS_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word splitter check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define QWS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word splitter check failed");

`endif

>>> hdl/qws_pkg.sv
// Package with character codes, quote state type and helpers for the word splitter.
`timescale 1ns / 1ps
`default_nettype none

package qws_pkg;

    // Byte codes that the splitter recognizes.
    localparam logic [7:0] WORD_MARK  = 8'h01;
    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam logic [7:0] SQUOTE     = 8'h27;
    localparam logic [7:0] DQUOTE     = 8'h22;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    // Which quote, if any, is open inside the current word.
    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_t;

    // Space, tab, LF, VT, FF or CR.
    function automatic logic is_space(input logic [7:0] b);
        return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    endfunction

endpackage

`default_nettype wire

>>> hdl/quoted_word_splitter.sv
// Shell-style word splitter: input register, per-byte state update and result queue.
//
// Usage: the input channel (in_valid, in_stall, in_byte, in_last) carries one
// character of a string per item, with in_last set on the final character.
// The output channel (out_valid, out_stall, out_byte, run_last) carries the
// split string: each word is the byte 0x01 followed by its characters, and
// run_last marks the last result that an input item caused. A string whose
// first byte is 0x01 is copied through unchanged, less any NUL bytes.
// Flow: an accepted item is held in the input register, is processed from
// there into the result queue, and its first result is taken from entry 0
// of that queue.
// Throughput: one item per cycle while items give at most one result each
// and out_stall is low. An item that opens a word with neither a quote mark
// nor a backslash gives two results, taken only into an empty result queue.
// NUL bytes give no result; in a split string, syntax whitespace, quote marks
// and backslashes give at most a word mark. All splitting state returns to its
// reset value after the item flagged with in_last.
// Reset clears the input register, the result queue and the splitting state.
// When the receiver stalls, the result queue fills and in_stall rises once the
// item in the input register no longer fits.
`timescale 1ns / 1ps
`default_nettype none

module quoted_word_splitter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last
);
    import qws_pkg::*;

    `include "quoted_word_splitter_assert.svh"

    // Input register.
    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;

    // Splitting state.
    logic   at_start_reg, at_start_next;
    logic   pass_reg, pass_next;
    logic   inside_reg, inside_next;
    quote_t quote_reg, quote_next;
    logic   esc_reg, esc_next;

    // Result queue, entry 0 is shown on the output ports.
    logic [7:0] ent_byte_reg [2];
    logic       ent_last_reg [2];
    logic [7:0] ent_byte_next [2];
    logic       ent_last_next [2];
    logic [1:0] count_reg, count_next;

    // Results of the item in the input register.
    logic       emit_mark;
    logic       emit_byte;
    logic [1:0] n_res;
    logic [7:0] r0_byte, r1_byte;
    logic       r0_last;

    logic       accept;
    logic       pop;
    logic       advance;
    logic [1:0] rem_cnt;
    logic [2:0] fill_sum;

    // Work out this item's results and the next splitting state.
    always_comb
    begin
        logic   pt;
        logic   handle;
        quote_t q;
        logic [7:0] b;
        b = a_byte_reg;
        emit_mark     = 1'b0;
        emit_byte     = 1'b0;
        at_start_next = at_start_reg;
        pass_next     = pass_reg;
        inside_next   = inside_reg;
        quote_next    = quote_reg;
        esc_next      = esc_reg;
        pt            = pass_reg;
        handle        = 1'b1;
        q             = quote_reg;
        if (b != NUL_CHAR)
        begin
            if (at_start_reg)
            begin
                at_start_next = 1'b0;
                pt            = (b == WORD_MARK);
                pass_next     = pt;
            end
            if (pt)
            begin
                emit_byte = 1'b1;
            end
            else if (esc_reg)
            begin
                esc_next  = 1'b0;
                emit_byte = 1'b1;
            end
            else
            begin
                if (!inside_reg)
                begin
                    if (is_space(b))
                    begin
                        handle = 1'b0;
                    end
                    else
                    begin
                        inside_next = 1'b1;
                        quote_next  = QUOTE_NONE;
                        q           = QUOTE_NONE;
                        emit_mark   = 1'b1;
                    end
                end
                if (handle)
                begin
                    if (b == BACKSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        case (q)
                            QUOTE_SINGLE:
                            begin
                                if (b == SQUOTE)
                                    quote_next = QUOTE_NONE;
                                else
                                    emit_byte = 1'b1;
                            end
                            QUOTE_DOUBLE:
                            begin
                                if (b == DQUOTE)
                                    quote_next = QUOTE_NONE;
                                else
                                    emit_byte = 1'b1;
                            end
                            default:
                            begin
                                if (is_space(b))
                                begin
                                    inside_next = 1'b0;
                                    quote_next  = QUOTE_NONE;
                                end
                                else if (b == SQUOTE)
                                    quote_next = QUOTE_SINGLE;
                                else if (b == DQUOTE)
                                    quote_next = QUOTE_DOUBLE;
                                else
                                    emit_byte = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end
        // The final byte returns everything to the start of a string.
        if (a_last_reg)
        begin
            at_start_next = 1'b1;
            pass_next     = 1'b0;
            inside_next   = 1'b0;
            quote_next    = QUOTE_NONE;
            esc_next      = 1'b0;
        end
    end

    // Order the results: word mark first, run_last on the final one.
    assign n_res   = {1'b0, emit_mark} + {1'b0, emit_byte};
    assign r0_byte = emit_mark ? WORD_MARK : a_byte_reg;
    assign r0_last = !(emit_mark && emit_byte);
    assign r1_byte = a_byte_reg;

    // Handshakes and queue room.
    assign pop      = out_valid && !out_stall;
    assign rem_cnt  = count_reg - {1'b0, pop};
    assign fill_sum = {1'b0, rem_cnt} + {1'b0, n_res};
    assign advance  = a_valid_reg && (fill_sum <= 3'd2);
    assign in_stall = a_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Next contents of the result queue.
    always_comb
    begin
        ent_byte_next[0] = pop ? ent_byte_reg[1] : ent_byte_reg[0];
        ent_last_next[0] = pop ? ent_last_reg[1] : ent_last_reg[0];
        ent_byte_next[1] = ent_byte_reg[1];
        ent_last_next[1] = ent_last_reg[1];
        count_next       = rem_cnt;
        if (advance)
        begin
            count_next = fill_sum[1:0];
            case (rem_cnt)
                2'd0:
                begin
                    ent_byte_next[0] = r0_byte;
                    ent_last_next[0] = r0_last;
                    ent_byte_next[1] = r1_byte;
                    ent_last_next[1] = 1'b1;
                end
                2'd1:
                begin
                    ent_byte_next[1] = r0_byte;
                    ent_last_next[1] = r0_last;
                end
                default:
                begin
                    ent_byte_next[1] = ent_byte_reg[1];
                    ent_last_next[1] = ent_last_reg[1];
                end
            endcase
        end
    end

    // Input register holds an item until it is processed.
    always_comb
    begin
        if (accept)
            a_valid_next = 1'b1;
        else if (advance)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    // Control and splitting state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            count_reg    <= 2'd0;
            at_start_reg <= 1'b1;
            pass_reg     <= 1'b0;
            inside_reg   <= 1'b0;
            quote_reg    <= QUOTE_NONE;
            esc_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            count_reg   <= count_next;
            if (advance)
            begin
                at_start_reg <= at_start_next;
                pass_reg     <= pass_next;
                inside_reg   <= inside_next;
                quote_reg    <= quote_next;
                esc_reg      <= esc_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_byte_reg <= in_byte;
            a_last_reg <= in_last;
        end
        ent_byte_reg[0] <= ent_byte_next[0];
        ent_byte_reg[1] <= ent_byte_next[1];
        ent_last_reg[0] <= ent_last_next[0];
        ent_last_reg[1] <= ent_last_next[1];
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_byte  = ent_byte_reg[0];
    assign run_last  = ent_last_reg[0];

    // The queue never holds more than two results.
    `QWS_CHECK(a_queue_bound, 1'b1, count_reg != 2'd3)
    // Two results are only written into an empty queue.
    `QWS_CHECK(a_pair_fits, advance && (n_res == 2'd2), rem_cnt == 2'd0)
    // A stalled item stays in the input register.
    `QWS_CHECK_NEXT(a_hold_item, a_valid_reg && in_stall, a_valid_reg)
    // A copied-through string never opens words or escapes.
    `QWS_CHECK(a_pass_clean, pass_reg, !inside_reg && !esc_reg)
    // At the start of a string all other state is at its reset value.
    `QWS_CHECK(a_start_clean, at_start_reg,
        !pass_reg && !inside_reg && !esc_reg && (quote_reg == QUOTE_NONE))

endmodule

`default_nettype wire

>>> tb/split_checker.sv
// Checker for the word splitter: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps

module split_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       run_last,
    output int         mismatch_count,
    output int         awaited_count,
    output int         checked_count
);
    import qws_pkg::*;

    // One predicted output byte and its end-of-run flag.
    typedef struct packed {
        logic [7:0] chr;
        logic       ends_run;
    } split_byte_t;

    // Output bytes predicted but not yet seen, oldest first.
    split_byte_t awaited_bytes[$];

    // Splitting state of the predictor.
    logic   at_start;
    logic   copy_through;
    logic   in_word;
    logic   esc_pending;
    quote_t quote_open;

    initial
    begin
        mismatch_count = 0;
        awaited_count  = 0;
        checked_count  = 0;
    end

    // Whitespace as the splitter sees it: space, tab, LF, VT, FF and CR.
    function automatic logic blank(input logic [7:0] b);
        return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    endfunction

    // Back to the state at the start of a string.
    task automatic clear_split_state();
        at_start     = 1'b1;
        copy_through = 1'b0;
        in_word      = 1'b0;
        esc_pending  = 1'b0;
        quote_open   = QUOTE_NONE;
    endtask

    // Work out the output bytes that one input character causes and queue them.
    task automatic predict_split(input logic [7:0] b, input logic final_char);
        split_byte_t produced[$];
        logic [7:0]  closing;
        logic        consume;
        if (b != NUL_CHAR)
        begin
            if (at_start)
            begin
                at_start     = 1'b0;
                copy_through = (b == WORD_MARK);
            end
            if (copy_through)
            begin
                produced.push_back('{chr: b, ends_run: 1'b0});
            end
            else if (esc_pending)
            begin
                esc_pending = 1'b0;
                produced.push_back('{chr: b, ends_run: 1'b0});
            end
            else
            begin
                consume = 1'b1;
                // A character outside a word either is skipped or opens a new word.
                if (!in_word)
                begin
                    if (blank(b))
                    begin
                        consume = 1'b0;
                    end
                    else
                    begin
                        in_word    = 1'b1;
                        quote_open = QUOTE_NONE;
                        produced.push_back('{chr: WORD_MARK, ends_run: 1'b0});
                    end
                end
                if (consume)
                begin
                    case (quote_open)
                        QUOTE_SINGLE: closing = SQUOTE;
                        QUOTE_DOUBLE: closing = DQUOTE;
                        default:      closing = NUL_CHAR;
                    endcase
                    if (b == BACKSLASH)
                    begin
                        esc_pending = 1'b1;
                    end
                    else if (closing != NUL_CHAR)
                    begin
                        if (b == closing)
                            quote_open = QUOTE_NONE;
                        else
                            produced.push_back('{chr: b, ends_run: 1'b0});
                    end
                    else if (blank(b))
                    begin
                        in_word    = 1'b0;
                        quote_open = QUOTE_NONE;
                    end
                    else if (b == SQUOTE)
                    begin
                        quote_open = QUOTE_SINGLE;
                    end
                    else if (b == DQUOTE)
                    begin
                        quote_open = QUOTE_DOUBLE;
                    end
                    else
                    begin
                        produced.push_back('{chr: b, ends_run: 1'b0});
                    end
                end
            end
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].ends_run = 1'b1;
        foreach (produced[i])
            awaited_bytes.push_back(produced[i]);
        if (final_char)
            clear_split_state();
    endtask

    // Compare each accepted result first, then predict from each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        split_byte_t want;
        if (!rst_n)
        begin
            awaited_bytes.delete();
            clear_split_state();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked_count++;
                if (awaited_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, out_byte %02h run_last %0b",
                             $time, out_byte, run_last);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_bytes.pop_front();
                    if (out_byte !== want.chr)
                    begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.chr, out_byte);
                        mismatch_count++;
                    end
                    if (run_last !== want.ends_run)
                    begin
                        $display("%0t: run_last expected %0b, got %0b",
                                 $time, want.ends_run, run_last);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_split(in_byte, in_last);
        end
        awaited_count = awaited_bytes.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the word splitter testbench: clock, reset, string stimulus, pacing and verdict.
`timescale 1ns / 1ps

module testbench;
    import qws_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int ITEMS_PER_PHASE = 480;
    localparam int FREEZE_LEN      = 300;
    localparam int DRAIN_CYCLES    = 12;

    localparam logic [7:0] LF_CHAR = 8'h0A;
    localparam logic [7:0] VT_CHAR = 8'h0B;
    localparam logic [7:0] FF_CHAR = 8'h0C;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_last;

    int mismatch_count;
    int awaited_count;
    int checked_count;

    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int freeze_requests = 0;
    int freeze_served   = 0;
    int chars_sent      = 0;
    int strings_sent    = 0;

    // Characters of the string being sent.
    logic [7:0] line_chars[$];

    quoted_word_splitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    split_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count),
        .checked_count  (checked_count)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Give up when the run takes far longer than any correct run could.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still awaited",
                 cycle_count, awaited_count);
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (freeze_served != freeze_requests)
            begin
                freeze_served++;
                out_stall <= 1'b1;
                repeat (FREEZE_LEN - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // A nonzero character that is neither whitespace, a quote nor a backslash.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = SQUOTE;
        while (c == SQUOTE || c == DQUOTE || c == BACKSLASH || is_space(c))
            c = 8'($urandom_range(255, 1));
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? SPACE_CHAR : 8'(TAB_CHAR + r);
    endfunction

    // A quoted piece of a word; its content may hold whitespace and escapes.
    function automatic void add_quoted(input logic [7:0] q);
        logic [7:0] c;
        line_chars.push_back(q);
        repeat ($urandom_range(5))
        begin
            if ($urandom_range(7) == 0)
            begin
                line_chars.push_back(BACKSLASH);
                line_chars.push_back(8'($urandom_range(255, 1)));
            end
            else
            begin
                c = 8'($urandom_range(255, 1));
                if (c == q || c == BACKSLASH)
                    c = blank_char();
                line_chars.push_back(c);
            end
        end
        line_chars.push_back(q);
    endfunction

    // One word built from plain runs, quoted pieces and escaped characters.
    function automatic void add_word();
        repeat ($urandom_range(3, 1))
        begin
            case ($urandom_range(4))
                0, 1:
                    repeat ($urandom_range(4, 1)) line_chars.push_back(plain_char());
                2:
                    add_quoted(SQUOTE);
                3:
                    add_quoted(DQUOTE);
                default:
                begin
                    line_chars.push_back(BACKSLASH);
                    line_chars.push_back(8'($urandom_range(255, 1)));
                end
            endcase
        end
    endfunction

    // Mostly well-formed command lines, some pass-through strings, some raw noise.
    function automatic void make_random_line();
        int kind;
        kind = $urandom_range(99);
        line_chars.delete();
        if (kind < 8)
        begin
            line_chars.push_back(WORD_MARK);
            repeat ($urandom_range(8)) line_chars.push_back(8'($urandom_range(255, 1)));
        end
        else if (kind < 14)
        begin
            repeat ($urandom_range(10, 1)) line_chars.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(3) == 0)
                line_chars.push_back(blank_char());
            add_word();
            repeat ($urandom_range(3))
            begin
                repeat ($urandom_range(3, 1)) line_chars.push_back(blank_char());
                add_word();
            end
            // Broken endings: trailing blanks, an unclosed quote or a lone backslash.
            case ($urandom_range(9))
                0: line_chars.push_back(blank_char());
                1: line_chars.push_back(($urandom_range(1) == 0) ? SQUOTE : DQUOTE);
                2: line_chars.push_back(BACKSLASH);
                default: ;
            endcase
        end
    endfunction

    // Offer one character and wait until the block takes it.
    task automatic send_char(input logic [7:0] b, input logic final_char);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= final_char;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (b != NUL_CHAR)
            chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_chars[i])
            send_char(line_chars[i], i == line_chars.size() - 1);
        strings_sent++;
    endtask

    // Stop offering items until every predicted result has come out.
    // The count is read only after a further clock edge, once the last accepted item is predicted.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaited_count == 0);
        @(posedge clk);
    endtask

    // Main sequence: reset, directed strings, paced random phases, verdict.
    initial
    begin
        int phase_start;
        int idle_pct[4];
        int stall_pct[4];
        idle_pct  = '{0, 88, 0, 26};
        stall_pct = '{0, 0, 88, 26};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = NUL_CHAR;
        in_last  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pass-through with extreme bytes.
        line_chars = '{WORD_MARK, SPACE_CHAR, 8'hFF};
        send_line();
        // Leading blank, empty quoted word, backslash on the final character.
        line_chars = '{TAB_CHAR, SQUOTE, SQUOTE, VT_CHAR, BACKSLASH};
        send_line();
        // Escaped quote inside double quotes, NUL byte, quote still open at the end.
        line_chars = '{DQUOTE, 8'h61, BACKSLASH, DQUOTE, LF_CHAR, NUL_CHAR, 8'h62};
        send_line();
        // Escape inside single quotes and whitespace kept inside them.
        line_chars = '{8'h78, FF_CHAR, SQUOTE, BACKSLASH, SQUOTE, CR_CHAR};
        send_line();
        // High-bit character, then NUL carrying the final flag.
        line_chars = '{8'h80, NUL_CHAR};
        send_line();
        drain_outputs();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct <= stall_pct[ph];
            phase_start    = chars_sent;
            // Hold the receiver off while the sender keeps pushing.
            if (ph == 0)
                freeze_requests <= freeze_requests + 1;
            while (chars_sent - phase_start < ITEMS_PER_PHASE)
            begin
                make_random_line();
                send_line();
            end
            drain_outputs();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d characters in %0d strings under four pacing mixes;",
                 chars_sent, strings_sent);
        $display("checked %0d output bytes, including a %0d-cycle receiver hold-off.",
                 checked_count, FREEZE_LEN);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
